[sv/ldfd_pkg.sv]
// Shared types, constants and the digit address table for the LED frame deframer.
package ldfd_pkg;

  localparam int unsigned NumPixels  = 208;
  localparam int unsigned PixCntW    = $clog2(NumPixels + 1);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned NumDigits  = 7;
  localparam int unsigned StepW      = 3;
  localparam logic [15:0] Div10Recip = 16'hCCCD;
  localparam int unsigned Div10Shift = 19;
  localparam logic [7:0]  SyncReset  = 8'hFF;

  typedef enum logic [1:0] {
    KindPixel = 2'd0,
    KindDigit = 2'd1,
    KindFrame = 2'd2
  } kind_e;

  typedef struct packed {
    logic        is_score;
    logic [7:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] score;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  digit_address;
    logic [3:0]  digit_value;
    logic [15:0] score_value;
    logic        last;
  } result_t;

  function automatic logic [2:0] digit_addr(input logic [StepW-1:0] step);
    logic [2:0] addr;
    unique case (step)
      3'd0:    addr = 3'd4;
      3'd1:    addr = 3'd5;
      3'd2:    addr = 3'd6;
      3'd3:    addr = 3'd1;
      3'd4:    addr = 3'd2;
      3'd5:    addr = 3'd3;
      default: addr = 3'd4;
    endcase
    return addr;
  endfunction

endpackage

[sv/ldfd_fifo.sv]
// Command queue between the frame parser and the result sequencer.
module ldfd_fifo
  import ldfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[sv/ldfd_front.sv]
// Frame parser: sync search, color gathering and score assembly into queue commands.
module ldfd_front
  import ldfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       queue_full_i,
  output logic       byte_ready_o,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  localparam logic [1:0] PhWait = 2'd0;
  localparam logic [1:0] PhPix  = 2'd1;
  localparam logic [1:0] PhShi  = 2'd2;
  localparam logic [1:0] PhSlo  = 2'd3;

  localparam logic [1:0] ChRed   = 2'd0;
  localparam logic [1:0] ChGreen = 2'd1;
  localparam logic [1:0] ChBlue  = 2'd2;

  logic [7:0]         sync_q;
  logic [1:0]         phase_q, phase_d;
  logic [1:0]         chan_q, chan_d;
  logic [PixCntW-1:0] count_q, count_d;
  logic [7:0]         red_q, red_d, green_q, green_d, high_q, high_d;
  logic               take;

  assign byte_ready_o = !queue_full_i;
  assign take         = byte_valid_i && !queue_full_i;

  always_comb begin
    phase_d    = phase_q;
    chan_d     = chan_q;
    count_d    = count_q;
    red_d      = red_q;
    green_d    = green_q;
    high_d     = high_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    if (take) begin
      unique case (phase_q)
        PhWait: begin
          if (byte_i == sync_q) begin
            phase_d = PhPix;
            chan_d  = ChRed;
            count_d = '0;
          end
        end
        PhPix: begin
          if (chan_q == ChRed) begin
            red_d  = byte_i;
            chan_d = ChGreen;
          end else if (chan_q == ChGreen) begin
            green_d = byte_i;
            chan_d  = ChBlue;
          end else begin
            push_o                 = 1'b1;
            push_cmd_o.pixel_index = 8'(count_q);
            push_cmd_o.red         = red_q;
            push_cmd_o.green       = green_q;
            push_cmd_o.blue        = byte_i;
            chan_d                 = ChRed;
            if (count_q == PixCntW'(NumPixels - 1)) begin
              count_d = '0;
              phase_d = PhShi;
            end else begin
              count_d = count_q + 1'b1;
            end
          end
        end
        PhShi: begin
          high_d  = byte_i;
          phase_d = PhSlo;
        end
        PhSlo: begin
          push_o              = 1'b1;
          push_cmd_o.is_score = 1'b1;
          push_cmd_o.score    = {high_q, byte_i};
          phase_d             = PhWait;
          count_d             = '0;
          chan_d              = ChRed;
        end
        default: phase_d = PhWait;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= SyncReset;
      phase_q <= PhWait;
      chan_q  <= ChRed;
      count_q <= '0;
      red_q   <= '0;
      green_q <= '0;
      high_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      chan_q  <= chan_d;
      count_q <= count_d;
      red_q   <= red_d;
      green_q <= green_d;
      high_q  <= high_d;
    end
  end

endmodule

[sv/ldfd_back.sv]
// Result sequencer: pixel writes, digit writes by division by ten, frame complete.
module ldfd_back
  import ldfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    queue_empty_i,
  input  cmd_t    head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [15:0]      num_q, num_d, score_q, score_d;
  logic             load;
  logic [15:0]      div_src, quo, quo_x10;
  logic [31:0]      prod;
  logic [3:0]       rem;

  assign load    = !out_valid_q || out_ready_i;
  assign div_src = busy_q ? num_q : head_i.score;
  assign prod    = div_src * Div10Recip;
  assign quo     = 16'(prod >> Div10Shift);
  assign quo_x10 = (quo << 3) + (quo << 1);
  assign rem     = 4'(div_src - quo_x10);
  assign pop_o   = load && !busy_q && !queue_empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    busy_d      = busy_q;
    step_d      = step_q;
    num_d       = num_q;
    score_d     = score_q;
    if (load) begin
      out_valid_d = busy_q || !queue_empty_i;
      out_d       = '0;
      if (busy_q) begin
        if (step_q == StepW'(NumDigits)) begin
          out_d.kind        = KindFrame;
          out_d.score_value = score_q;
          out_d.last        = 1'b1;
          busy_d            = 1'b0;
        end else begin
          out_d.kind          = KindDigit;
          out_d.digit_address = digit_addr(step_q);
          out_d.digit_value   = rem;
          num_d               = quo;
          step_d              = step_q + 1'b1;
        end
      end else if (!queue_empty_i) begin
        if (head_i.is_score) begin
          out_d.kind          = KindDigit;
          out_d.digit_address = digit_addr('0);
          out_d.digit_value   = rem;
          num_d               = quo;
          score_d             = head_i.score;
          step_d              = StepW'(1);
          busy_d              = 1'b1;
        end else begin
          out_d.kind        = KindPixel;
          out_d.pixel_index = head_i.pixel_index;
          out_d.red         = head_i.red;
          out_d.green       = head_i.green;
          out_d.blue        = head_i.blue;
          out_d.last        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    num_q   <= num_d;
    score_q <= score_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[sv/led_frame_deframer_with_score_digits.sv]
// Top level of the LED frame deframer with score digit writes.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: rx_byte
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata, tuser: kind, tlast: last
//   cfg       in   cfg_we_i                      cfg_wdata_i: sync_value
//
// One byte per cycle enters while the 4-command queue has room.
// A pixel command leaves as one item; a score command leaves as eight items
// one after another, paced by the single divide-by-ten multiplier in the back.
// Reset: waiting for sync, sync value 0xFF, queue and output register empty.
// Either side may stall; the queue and output register decouple them.
module led_frame_deframer_with_score_digits
  import ldfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_index, [15:8] red, [23:16] green, [31:24] blue,
  // [34:32] digit_address, [38:35] digit_value, [54:39] score_value, [55] zero
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast
);

  logic    push, pop, q_empty, q_full;
  cmd_t    push_cmd, head;
  result_t res;

  ldfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .queue_full_i (q_full),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  ldfd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  ldfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_o         (res)
  );

  assign m_axis_tdata = {1'b0, res.score_value, res.digit_value, res.digit_address,
                         res.blue, res.green, res.red, res.pixel_index};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
